### rtl/luhn_card_number_classifier_assert.svh
// Assertion macros shared by the card number classifier RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LUHN_CARD_NUMBER_CLASSIFIER_ASSERT_SVH
`define LUHN_CARD_NUMBER_CLASSIFIER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define LUHN_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another one in the same cycle.
`define LUHN_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that implies another one in the next cycle.
`define LUHN_IMPLIES_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/luhn_pkg.sv
// Package for the card number classifier: widths, brand codes and small helper functions.
// Used by every RTL module of the block; depends on nothing.
package luhn_pkg;

  localparam int CARD_W         = 63;
  localparam int BCD_DIGITS     = 19;
  localparam int BCD_W          = BCD_DIGITS * 4;
  localparam int GROUP_SIZE     = 4;
  localparam int GROUPS         = (BCD_DIGITS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int MAX_DIGITS_DEF = 19;

  localparam int COUNT_W = 5;
  localparam int GSUM_W  = 6;
  localparam int SUM_W   = 8;

  localparam logic [COUNT_W-1:0] VISA_LEN_SHORT = 5'd13;
  localparam logic [COUNT_W-1:0] AMEX_LEN       = 5'd15;
  localparam logic [COUNT_W-1:0] STD_LEN        = 5'd16;
  localparam logic [3:0]         VISA_LEAD      = 4'd4;
  localparam logic [6:0]         AMEX_PAIR_A    = 7'd34;
  localparam logic [6:0]         AMEX_PAIR_B    = 7'd37;
  localparam logic [6:0]         JCB_PAIR       = 7'd35;
  localparam logic [6:0]         MC_PAIR_LO     = 7'd51;
  localparam logic [6:0]         MC_PAIR_HI     = 7'd55;

  typedef enum logic [2:0] {
    BRAND_INVALID = 3'd0,
    BRAND_VISA    = 3'd1,
    BRAND_AMEX    = 3'd2,
    BRAND_JCB     = 3'd3,
    BRAND_MASTER  = 3'd4
  } brand_t;

  typedef logic [BCD_W-1:0]  bcd_t;
  typedef logic [CARD_W-1:0] card_t;

  // Luhn contribution of one digit; doubled digits fold to their digit sum.
  function automatic logic [3:0] luhn_val(input logic [3:0] dig, input logic dbl);
    logic [4:0] d2;
    d2 = {dig, 1'b0};
    if (!dbl) begin
      return dig;
    end else if (d2 > 5'd9) begin
      return 4'(d2 - 5'd9);
    end else begin
      return d2[3:0];
    end
  endfunction

  // True when an 8-bit sum (at most 171) is a multiple of ten.
  // The quotient comes from a multiply by the reciprocal 205/2048.
  function automatic logic is_mult10(input logic [SUM_W-1:0] s);
    logic [15:0] p;
    logic [4:0]  q;
    logic [7:0]  t;
    p = {8'b0, s} * 16'd205;
    q = p[15:11];
    t = 8'({3'b0, q} * 8'd10);
    return (s - t) == 8'd0;
  endfunction

  function automatic brand_t classify(input logic [COUNT_W-1:0] count,
                                      input logic [3:0] lead,
                                      input logic [3:0] prev);
    logic [6:0] pair;
    pair = 7'({3'b0, lead} * 7'd10) + {3'b0, prev};
    if ((count == VISA_LEN_SHORT || count == STD_LEN) && lead == VISA_LEAD) begin
      return BRAND_VISA;
    end else if (count == AMEX_LEN && (pair == AMEX_PAIR_A || pair == AMEX_PAIR_B)) begin
      return BRAND_AMEX;
    end else if (count == STD_LEN && pair == JCB_PAIR) begin
      return BRAND_JCB;
    end else if (count == STD_LEN && (pair inside {[MC_PAIR_LO:MC_PAIR_HI]})) begin
      return BRAND_MASTER;
    end else begin
      return BRAND_INVALID;
    end
  endfunction

endpackage

### rtl/luhn_dd_stage.sv
// One registered step of the binary to BCD conversion (shift and add three).
// Depends on luhn_pkg for the digit and card widths.
module luhn_dd_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ce,
  input  logic                  vld_in,
  input  luhn_pkg::bcd_t        bcd_in,
  input  luhn_pkg::card_t       bin_in,
  output logic                  vld,
  output luhn_pkg::bcd_t        bcd,
  output luhn_pkg::card_t       bin
);
  import luhn_pkg::*;

  bcd_t adj;

  // Every digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_in[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_in[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_in[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ce) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      bcd <= {adj[BCD_W-2:0], bin_in[CARD_W-1]};
      bin <= {bin_in[CARD_W-2:0], 1'b0};
    end
  end

endmodule

### rtl/luhn_score.sv
// Two pipeline stages that turn decimal digits into Luhn group sums, digit count and
// overflow, then into the total sum and the two leading digits. Depends on luhn_pkg.
module luhn_score #(
  parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ce,
  input  logic                         vld_in,
  input  luhn_pkg::bcd_t               digits_in,
  output logic                         vld,
  output logic [luhn_pkg::SUM_W-1:0]   sum,
  output logic [luhn_pkg::COUNT_W-1:0] count,
  output logic [3:0]                   lead,
  output logic [3:0]                   prev,
  output logic                         ovf
);
  import luhn_pkg::*;

  // First stage registers.
  logic                vld_a;
  bcd_t                digits_a;
  logic [GSUM_W-1:0]   gsum_a [GROUPS];
  logic [COUNT_W-1:0]  count_a;
  logic                ovf_a;

  logic [GSUM_W-1:0]   gsum_next [GROUPS];
  logic [COUNT_W-1:0]  count_a_next;
  logic                ovf_a_next;

  logic [SUM_W-1:0]    sum_next;
  logic [3:0]          lead_next;
  logic [3:0]          prev_next;

  // Digit index i counts from the right starting at zero, so odd indexes are doubled.
  always_comb begin
    ovf_a_next   = 1'b0;
    count_a_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      gsum_next[g] = '0;
    end
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (i < MAX_DIGITS) begin
        gsum_next[i / GROUP_SIZE] = gsum_next[i / GROUP_SIZE]
                                  + GSUM_W'(luhn_val(digits_in[i*4 +: 4], i[0]));
      end else if (digits_in[i*4 +: 4] != 4'd0) begin
        ovf_a_next = 1'b1;
      end
      if (digits_in[i*4 +: 4] != 4'd0) begin
        count_a_next = COUNT_W'(i + 1);
      end
    end
    if (ovf_a_next) begin
      count_a_next = COUNT_W'(MAX_DIGITS);
    end
  end

  always_comb begin
    sum_next  = '0;
    lead_next = 4'd0;
    prev_next = 4'd0;
    for (int g = 0; g < GROUPS; g++) begin
      sum_next = sum_next + SUM_W'(gsum_a[g]);
    end
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (count_a == COUNT_W'(i + 1)) begin
        lead_next = digits_a[i*4 +: 4];
        if (i > 0) begin
          prev_next = digits_a[(i-1)*4 +: 4];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld   <= 1'b0;
    end else if (ce) begin
      vld_a <= vld_in;
      vld   <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      digits_a <= digits_in;
      gsum_a   <= gsum_next;
      count_a  <= count_a_next;
      ovf_a    <= ovf_a_next;
      sum      <= sum_next;
      count    <= count_a;
      ovf      <= ovf_a;
      lead     <= lead_next;
      prev     <= prev_next;
    end
  end

endmodule

### rtl/luhn_brand.sv
// Output stage: Luhn verdict from the digit sum and brand from length and prefix.
// Depends on luhn_pkg for the brand codes and the check functions.
module luhn_brand (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ce,
  input  logic                         vld_in,
  input  logic [luhn_pkg::SUM_W-1:0]   sum,
  input  logic [luhn_pkg::COUNT_W-1:0] count,
  input  logic [3:0]                   lead,
  input  logic [3:0]                   prev,
  input  logic                         ovf,
  output logic                         vld,
  output logic                         luhn_ok,
  output logic [luhn_pkg::COUNT_W-1:0] digit_count,
  output luhn_pkg::brand_t             brand
);
  import luhn_pkg::*;

  logic   ok_next;
  brand_t brand_next;

  always_comb begin
    ok_next    = !ovf && is_mult10(sum);
    brand_next = ok_next ? classify(count, lead, prev) : BRAND_INVALID;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ce) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      luhn_ok     <= ok_next;
      digit_count <= count;
      brand       <= brand_next;
    end
  end

endmodule

### rtl/luhn_card_number_classifier.sv
// Pipeline: 63 conversion stages, one bit of the card number each, then two scoring
// stages and the output stage; each accepted input beat yields one result beat.
// Throughput: one beat per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, active high; clears every stage valid bit, payload is not reset.
// Depends on luhn_pkg, luhn_dd_stage, luhn_score, luhn_brand and the assertion header.
module luhn_card_number_classifier #(
  parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [62:0] card_number, [63] zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] luhn_ok, [5:1] digit_count, [8:6] brand,
                                      // [15:9] zero fill
);
  import luhn_pkg::*;

  `include "luhn_card_number_classifier_assert.svh"

  // The pipeline moves as one: every stage advances whenever the output register is
  // empty or its beat is being taken. Nothing is dropped or duplicated on a stall
  // because every register, valid bits included, simply holds.
  logic ce;

  // Binary to BCD conversion chain; entry 0 is the input beat itself.
  logic [CARD_W:0] dd_vld;
  bcd_t            dd_bcd [CARD_W+1];
  card_t           dd_bin [CARD_W+1];

  logic                 sc_vld;
  logic [SUM_W-1:0]     sc_sum;
  logic [COUNT_W-1:0]   sc_count;
  logic [3:0]           sc_lead;
  logic [3:0]           sc_prev;
  logic                 sc_ovf;

  logic                 out_vld;
  logic                 out_ok;
  logic [COUNT_W-1:0]   out_count;
  brand_t               out_brand;

  assign ce            = !out_vld || m_axis_tready;
  assign s_axis_tready = ce;

  assign dd_vld[0] = s_axis_tvalid;
  assign dd_bcd[0] = '0;
  assign dd_bin[0] = s_axis_tdata[CARD_W-1:0];

  // One conversion stage per input bit, most significant bit first. After the last
  // stage the BCD word holds all nineteen decimal digits of the card number.
  for (genvar k = 0; k < CARD_W; k++) begin : g_dd
    luhn_dd_stage u_stage (
      .clk    (clk),
      .rst    (rst),
      .ce     (ce),
      .vld_in (dd_vld[k]),
      .bcd_in (dd_bcd[k]),
      .bin_in (dd_bin[k]),
      .vld    (dd_vld[k+1]),
      .bcd    (dd_bcd[k+1]),
      .bin    (dd_bin[k+1])
    );
  end

  // Luhn weighting, digit count, leading digits and the digit-limit overflow check.
  luhn_score #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_score (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .vld_in    (dd_vld[CARD_W]),
    .digits_in (dd_bcd[CARD_W]),
    .vld       (sc_vld),
    .sum       (sc_sum),
    .count     (sc_count),
    .lead      (sc_lead),
    .prev      (sc_prev),
    .ovf       (sc_ovf)
  );

  // Final verdict; this stage is also the output register.
  luhn_brand u_brand (
    .clk         (clk),
    .rst         (rst),
    .ce          (ce),
    .vld_in      (sc_vld),
    .sum         (sc_sum),
    .count       (sc_count),
    .lead        (sc_lead),
    .prev        (sc_prev),
    .ovf         (sc_ovf),
    .vld         (out_vld),
    .luhn_ok     (out_ok),
    .digit_count (out_count),
    .brand       (out_brand)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {7'b0, out_brand, out_count, out_ok};

  // A named brand only ever follows a passing Luhn check.
  `LUHN_IMPLIES(a_brand_needs_ok, m_axis_tvalid && out_brand != BRAND_INVALID, out_ok,
                "brand reported for a number that failed the Luhn check")
  // The digit count never exceeds the configured digit limit.
  `LUHN_IMPLIES(a_count_limit, m_axis_tvalid, out_count <= COUNT_W'(MAX_DIGITS),
                "digit count above the digit limit")
  // A visa result always comes with thirteen or sixteen digits.
  `LUHN_IMPLIES(a_visa_len, m_axis_tvalid && out_brand == BRAND_VISA,
                out_count == VISA_LEN_SHORT || out_count == STD_LEN,
                "visa brand with a wrong digit count")
  // The input side is held off only by a result that is waiting.
  `LUHN_IMPLIES(a_ready_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready,
                "input stalled without a pending result")
  // A stalled pipeline keeps the valid bits of the last conversion stage and of the scoring stage unchanged.
  `LUHN_IMPLIES_NEXT(a_stall_holds, !ce, $stable(dd_vld[CARD_W]) && $stable(sc_vld),
                     "pipeline stage changed during a stall")

endmodule
